// ===== rtl/core/arpc_pkg.sv =====
// Shared types and constants for the ARP cache engine.
`timescale 1ns / 1ps
package arpc_pkg;

  // Item kinds
  localparam logic [1:0] KIND_RESOLVE = 2'd0;
  localparam logic [1:0] KIND_ARP     = 2'd1;
  localparam logic [1:0] KIND_SWEEP   = 2'd2;

  // Resolve destination classes
  localparam logic [1:0] CAST_BCAST = 2'd1;
  localparam logic [1:0] CAST_MCAST = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_ANSWER   = 3'd0;
  localparam logic [2:0] ACT_TRANSMIT = 3'd1;
  localparam logic [2:0] ACT_RELEASE  = 3'd2;
  localparam logic [2:0] ACT_REQUEST  = 3'd3;
  localparam logic [2:0] ACT_REPLY    = 3'd4;
  localparam logic [2:0] ACT_DONE     = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_IP    = 3'd0;
  localparam logic [2:0] REG_OWN_MAC   = 3'd1;
  localparam logic [2:0] REG_KEEP_SEC  = 3'd2;
  localparam logic [2:0] REG_MAX_TRIES = 3'd3;
  localparam logic [2:0] REG_DOWN_SEC  = 3'd4;

  // Entry states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_SOLVED  = 2'd2;

  localparam int          MAX_RESULTS = 17;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAC_MCAST   = 48'h0100_5E00_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip_addr;
    logic [31:0] target_ip;
    logic [47:0] sender_mac;
    logic        is_request;
    logic [1:0]  cast_kind;
    logic [15:0] packet_handle;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dest_mac;
    logic [31:0] ip_addr_out;
    logic [15:0] handle;
    logic        resolved;
    logic        dup_ip_seen;
    logic        last;
  } out_item_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_SCAN_CLR, OP_SCAN, OP_SCAN_END, OP_SELECT,
    OP_READ_CUR, OP_LOAD_CUR, OP_NEW, OP_RES_HOLD, OP_LEARN, OP_WRITE,
    OP_DUP, OP_SW_RD, OP_SW_STEP
  } op_t;

  // Result selection
  typedef enum logic [3:0] {
    EM_NONE, EM_BCAST, EM_MCAST, EM_HIT, EM_MISS, EM_REL_CUR, EM_REL_RD,
    EM_REQUEST, EM_XMIT, EM_REPLY, EM_DONE
  } emit_t;

  typedef struct packed {
    op_t   op;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cast_kind;
    logic       smac_bcast;
    logic       ip_is_own;
    logic       cnt_last;
    logic       sel_none;
    logic       sel_alloc;
    logic       cur_hv;
    logic       cur_fresh;
    logic       req_flag;
    logic       xmit_flag;
    logic       reply_ok;
    logic       rd_expired;
    logic       rd_hv;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/arp_cache_engine_unit.sv =====
// Top level of the ARP cache engine: controller plus datapath.
// Broadcast/multicast resolves are answered without a table scan; other table items scan
//   every entry first; sweeps visit every entry and release each expired held entry.
// Items are taken one at a time; the entry memory read port sets the scan length.
// Results leave one at a time; each result waits in one output register.
// Reset (rst, synchronous): all entries free, config back to defaults, flag cleared.
`timescale 1ns / 1ps
module arp_cache_engine_unit #(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  arpc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output arpc_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import arpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  arpc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  arpc_datapath #(.ENTRIES(ENTRIES), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

endmodule

// ===== rtl/core/arpc_datapath.sv =====
// Datapath: entry memory, scan trackers, working entry, config and result register.
`timescale 1ns / 1ps
module arpc_datapath #(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  arpc_pkg::in_item_t  in_item,
  input  arpc_pkg::dp_cmd_t   cmd,
  output arpc_pkg::dp_status_t status,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output arpc_pkg::out_item_t out_item
);
  import arpc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  typedef struct packed {
    logic [31:0]   ip;
    logic [47:0]   mac;
    logic [1:0]    st;
    logic [31:0]   expire;
    logic [7:0]    tries;
    logic          hv;
    logic [HW-1:0] hold;
  } entry_t;

  // Config registers
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] keep_seconds;
  logic [7:0]  max_tries;
  logic [15:0] down_seconds;

  in_item_t item;
  logic [IW-1:0] cnt, ridx, cur_idx, rd_addr;
  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vbits;
  entry_t rentry, rd_e, cur;
  logic rvalid, rpipe, rd_en;
  logic match_found, fr_found, so_found, pe_found;
  logic [IW-1:0] match_idx, fr_idx, so_idx, pe_idx;
  logic [31:0] so_exp, pe_exp;
  logic sel_none, sel_alloc, req_flag, xmit_flag, dup;
  logic [HW-1:0] xmit_hold;
  logic [4:0] n_res;
  out_item_t res;
  logic load;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip <= '0;
      own_mac <= '0;
      keep_seconds <= 16'd1200;
      max_tries <= 8'd5;
      down_seconds <= 16'd20;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OWN_IP:    own_ip <= cfg_data[31:0];
        REG_OWN_MAC:   own_mac <= cfg_data;
        REG_KEEP_SEC:  keep_seconds <= cfg_data[15:0];
        REG_MAX_TRIES: max_tries <= cfg_data[7:0];
        REG_DOWN_SEC:  down_seconds <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Entry memory port
  assign rd_en = (cmd.op == OP_SCAN) || (cmd.op == OP_READ_CUR) || (cmd.op == OP_SW_RD);
  assign rd_addr = (cmd.op == OP_READ_CUR) ? cur_idx : cnt;
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) mem[cur_idx] <= cur;
    if (rd_en) begin
      rentry <= mem[rd_addr];
      ridx <= rd_addr;
    end
  end
  assign rd_e = rvalid ? rentry : '0;

  // Valid bits; a cleared entry reads as free and zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      rvalid <= 1'b0;
      rpipe <= 1'b0;
    end else begin
      rpipe <= rd_en;
      if (rd_en) rvalid <= vbits[rd_addr];
      if (cmd.op == OP_WRITE) vbits[cur_idx] <= 1'b1;
      if (cmd.op == OP_SW_STEP && status.rd_expired) vbits[ridx] <= 1'b0;
    end
  end

  // Item, scan trackers and working entry
  always_ff @(posedge clk) begin
    if (rst) begin
      dup <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LOAD_IN: item <= in_item;
        OP_SCAN_CLR: begin
          cnt <= '0;
          match_found <= 1'b0;
          fr_found <= 1'b0;
          so_found <= 1'b0;
          pe_found <= 1'b0;
        end
        OP_SELECT: begin
          if (match_found) begin
            sel_alloc <= 1'b0;
            sel_none <= 1'b0;
            cur_idx <= match_idx;
          end else if (item.kind == KIND_RESOLVE || item.target_ip == own_ip) begin
            sel_alloc <= 1'b1;
            sel_none <= 1'b0;
            cur_idx <= fr_found ? fr_idx : (so_found ? so_idx : pe_idx);
          end else begin
            sel_alloc <= 1'b0;
            sel_none <= 1'b1;
          end
        end
        OP_LOAD_CUR: cur <= rd_e;
        // fresh pending entry: ip, mac 0, expire now, tries 0, no hold
        OP_NEW: cur <= {item.ip_addr, 48'd0, ST_PENDING, item.now_seconds, 8'd0, 1'b0,
                        {HW{1'b0}}};
        OP_RES_HOLD: begin
          cur.hv <= 1'b1;
          cur.hold <= HW'(item.packet_handle);
          if (cur.tries == 8'd0 || cur.expire != item.now_seconds) begin
            if (cur.tries < max_tries) begin
              cur.expire <= item.now_seconds;
              cur.tries <= cur.tries + 8'd1;
              req_flag <= 1'b1;
            end else begin
              cur.expire <= item.now_seconds + 32'(down_seconds);
              cur.tries <= '0;
              req_flag <= 1'b0;
            end
          end else begin
            req_flag <= 1'b0;
          end
        end
        OP_LEARN: begin
          cur.mac <= item.sender_mac;
          cur.st <= ST_SOLVED;
          cur.expire <= item.now_seconds + 32'(keep_seconds);
          cur.tries <= '0;
          cur.hv <= 1'b0;
          cur.hold <= '0;
          xmit_flag <= cur.hv;
          xmit_hold <= cur.hold;
        end
        OP_DUP: dup <= 1'b1;
        OP_SCAN: cnt <= cnt + IW'(1);
        OP_SW_STEP: cnt <= cnt + IW'(1);
        default: ;
      endcase
      // Evaluate the entry read in the previous cycle
      if ((cmd.op == OP_SCAN || cmd.op == OP_SCAN_END) && rpipe) begin
        if (rvalid && rd_e.ip == item.ip_addr && !match_found) begin
          match_found <= 1'b1;
          match_idx <= ridx;
        end
        if (!rvalid) begin
          if (!fr_found) begin
            fr_found <= 1'b1;
            fr_idx <= ridx;
          end
        end else if (rd_e.st == ST_SOLVED) begin
          if (!so_found || rd_e.expire < so_exp) begin
            so_found <= 1'b1;
            so_idx <= ridx;
            so_exp <= rd_e.expire;
          end
        end else if (!pe_found || rd_e.expire < pe_exp) begin
          pe_found <= 1'b1;
          pe_idx <= ridx;
          pe_exp <= rd_e.expire;
        end
      end
    end
  end

  // Status toward the controller
  always_comb begin
    status.kind = item.kind;
    status.cast_kind = item.cast_kind;
    status.smac_bcast = (item.sender_mac == MAC_BCAST);
    status.ip_is_own = (item.ip_addr == own_ip);
    status.cnt_last = (cnt == IW'(ENTRIES - 1));
    status.sel_none = sel_none;
    status.sel_alloc = sel_alloc;
    status.cur_hv = cur.hv;
    status.cur_fresh = (cur.st == ST_SOLVED) && (cur.expire > item.now_seconds);
    status.req_flag = req_flag;
    status.xmit_flag = xmit_flag;
    status.reply_ok = item.is_request && (own_ip != '0) &&
                      (item.ip_addr == own_ip || item.target_ip == own_ip);
    status.rd_expired = (rd_e.expire != '0) && (rd_e.expire <= item.now_seconds);
    status.rd_hv = rd_e.hv;
    status.out_free = !out_valid;
  end

  // Result build
  always_comb begin
    res = '0;
    res.dup_ip_seen = dup;
    unique case (cmd.emit)
      EM_BCAST: begin
        res.action = ACT_ANSWER;
        res.dest_mac = MAC_BCAST;
        res.resolved = 1'b1;
        res.last = 1'b1;
      end
      EM_MCAST: begin
        res.action = ACT_ANSWER;
        res.dest_mac = MAC_MCAST | 48'(item.ip_addr[22:0]);
        res.resolved = 1'b1;
        res.last = 1'b1;
      end
      EM_HIT: begin
        res.action = ACT_ANSWER;
        res.dest_mac = cur.mac;
        res.resolved = 1'b1;
        res.last = 1'b1;
      end
      EM_MISS: begin
        res.action = ACT_ANSWER;
        res.last = 1'b1;
      end
      EM_REL_CUR: begin
        res.action = ACT_RELEASE;
        res.handle = 16'(cur.hold);
      end
      EM_REL_RD: begin
        res.action = ACT_RELEASE;
        res.handle = 16'(rd_e.hold);
      end
      EM_REQUEST: begin
        res.action = ACT_REQUEST;
        res.ip_addr_out = item.ip_addr;
      end
      EM_XMIT: begin
        res.action = ACT_TRANSMIT;
        res.dest_mac = item.sender_mac;
        res.handle = 16'(xmit_hold);
      end
      EM_REPLY: begin
        res.action = ACT_REPLY;
        res.dest_mac = item.sender_mac;
        res.ip_addr_out = item.ip_addr;
      end
      EM_DONE: begin
        res.action = ACT_DONE;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register; results past the per-item limit are dropped
  assign load = (cmd.emit != EM_NONE) && !out_valid && (n_res < 5'(MAX_RESULTS));
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      n_res <= '0;
    end else begin
      if (cmd.op == OP_LOAD_IN) n_res <= '0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (load) begin
        out_valid <= 1'b1;
        out_item <= res;
        n_res <= n_res + 5'd1;
      end
    end
  end

  a_res_limit: assert property (@(posedge clk) disable iff (rst)
    n_res <= 5'(MAX_RESULTS)) else $error("result count over limit");
  a_write_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_WRITE |=> vbits[$past(cur_idx)]) else $error("written entry not valid");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    load && res.last |-> res.action == ACT_ANSWER || res.action == ACT_DONE)
    else $error("final result has wrong action");

endmodule

// ===== rtl/core/arpc_ctrl.sv =====
// Controller: sequences scan, allocation, update and result transfers per item.
`timescale 1ns / 1ps
module arpc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  arpc_pkg::dp_status_t status,
  output arpc_pkg::dp_cmd_t    cmd
);
  import arpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_END, S_SELECT, S_RD_CUR, S_LOAD_CUR,
    S_VICT_REL, S_NEW, S_RES_CHK, S_RES_HIT, S_RES_REL, S_RES_HOLD, S_RES_REQ,
    S_RES_WR, S_RES_MISS, S_ARP_LEARN, S_ARP_WR, S_ARP_XMIT, S_REPLY, S_DONE,
    S_BCAST, S_MCAST, S_DUP, S_SW_RD, S_SW_CHK, S_SW_REL, S_SW_STEP
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.emit = EM_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD_IN;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (status.kind == KIND_RESOLVE) begin
          if (status.cast_kind == CAST_BCAST) state_next = S_BCAST;
          else if (status.cast_kind == CAST_MCAST) state_next = S_MCAST;
          else begin
            cmd.op = OP_SCAN_CLR;
            state_next = S_SCAN;
          end
        end else if (status.kind == KIND_ARP) begin
          if (status.smac_bcast) state_next = S_DONE;
          else if (status.ip_is_own) state_next = S_DUP;
          else begin
            cmd.op = OP_SCAN_CLR;
            state_next = S_SCAN;
          end
        end else if (status.kind == KIND_SWEEP) begin
          cmd.op = OP_SCAN_CLR;
          state_next = S_SW_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.cnt_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd.op = OP_SCAN_END;
        state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.op = OP_SELECT;
        state_next = S_RD_CUR;
      end
      S_RD_CUR: begin
        if (status.sel_none) state_next = S_REPLY;
        else begin
          cmd.op = OP_READ_CUR;
          state_next = S_LOAD_CUR;
        end
      end
      S_LOAD_CUR: begin
        cmd.op = OP_LOAD_CUR;
        if (status.sel_alloc) state_next = S_VICT_REL;
        else if (status.kind == KIND_RESOLVE) state_next = S_RES_CHK;
        else state_next = S_ARP_LEARN;
      end
      S_VICT_REL: begin
        if (!status.cur_hv) state_next = S_NEW;
        else begin
          cmd.emit = EM_REL_CUR;
          if (status.out_free) state_next = S_NEW;
        end
      end
      S_NEW: begin
        cmd.op = OP_NEW;
        state_next = (status.kind == KIND_RESOLVE) ? S_RES_CHK : S_ARP_LEARN;
      end
      S_RES_CHK: state_next = status.cur_fresh ? S_RES_HIT : S_RES_REL;
      S_RES_HIT: begin
        cmd.emit = EM_HIT;
        if (status.out_free) state_next = S_IDLE;
      end
      S_RES_REL: begin
        if (!status.cur_hv) state_next = S_RES_HOLD;
        else begin
          cmd.emit = EM_REL_CUR;
          if (status.out_free) state_next = S_RES_HOLD;
        end
      end
      S_RES_HOLD: begin
        cmd.op = OP_RES_HOLD;
        state_next = S_RES_REQ;
      end
      S_RES_REQ: begin
        if (!status.req_flag) state_next = S_RES_WR;
        else begin
          cmd.emit = EM_REQUEST;
          if (status.out_free) state_next = S_RES_WR;
        end
      end
      S_RES_WR: begin
        cmd.op = OP_WRITE;
        state_next = S_RES_MISS;
      end
      S_RES_MISS: begin
        cmd.emit = EM_MISS;
        if (status.out_free) state_next = S_IDLE;
      end
      S_ARP_LEARN: begin
        cmd.op = OP_LEARN;
        state_next = S_ARP_WR;
      end
      S_ARP_WR: begin
        cmd.op = OP_WRITE;
        state_next = S_ARP_XMIT;
      end
      S_ARP_XMIT: begin
        if (!status.xmit_flag) state_next = S_REPLY;
        else begin
          cmd.emit = EM_XMIT;
          if (status.out_free) state_next = S_REPLY;
        end
      end
      S_DUP: begin
        cmd.op = OP_DUP;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (!status.reply_ok) state_next = S_DONE;
        else begin
          cmd.emit = EM_REPLY;
          if (status.out_free) state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit = EM_DONE;
        if (status.out_free) state_next = S_IDLE;
      end
      S_BCAST: begin
        cmd.emit = EM_BCAST;
        if (status.out_free) state_next = S_IDLE;
      end
      S_MCAST: begin
        cmd.emit = EM_MCAST;
        if (status.out_free) state_next = S_IDLE;
      end
      S_SW_RD: begin
        cmd.op = OP_SW_RD;
        state_next = S_SW_CHK;
      end
      S_SW_CHK: begin
        state_next = (status.rd_expired && status.rd_hv) ? S_SW_REL : S_SW_STEP;
      end
      S_SW_REL: begin
        cmd.emit = EM_REL_RD;
        if (status.out_free) state_next = S_SW_STEP;
      end
      S_SW_STEP: begin
        cmd.op = OP_SW_STEP;
        state_next = status.cnt_last ? S_DONE : S_SW_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_DISPATCH) else $error("accept not dispatched");
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_END |=> state == S_SELECT) else $error("scan did not select");
  a_emit_idle_only: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cmd.emit == EM_NONE) else $error("result in idle");

endmodule

// ===== tb/tb_arp_cache_engine_unit.sv =====
// Testbench for the ARP cache engine: table predictor, scoreboard, random traffic.
`timescale 1ns / 1ps
module tb_arp_cache_engine_unit;
  import arpc_pkg::*;

  localparam int NENT = 16;
  localparam int WATCH_LIMIT = 20000;

  // ARP table predictor and queue of expected results
  class arp_scoreboard;
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [15:0] keep_sec;
    logic [7:0]  max_tries;
    logic [15:0] down_sec;
    logic [31:0] e_ip[NENT];
    logic [47:0] e_mac[NENT];
    logic [1:0]  e_st[NENT];
    logic [31:0] e_exp[NENT];
    logic [7:0]  e_tries[NENT];
    logic        e_hv[NENT];
    logic [15:0] e_hold[NENT];
    logic        dup;
    out_item_t   pending_q[$];
    int          errors;

    function void reset_state();
      own_ip = 0; own_mac = 0; keep_sec = 1200; max_tries = 5; down_sec = 20;
      for (int i = 0; i < NENT; i++) clear_slot(i);
      dup = 0;
      pending_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] d);
      case (idx)
        REG_OWN_IP:    own_ip = d[31:0];
        REG_OWN_MAC:   own_mac = d;
        REG_KEEP_SEC:  keep_sec = d[15:0];
        REG_MAX_TRIES: max_tries = d[7:0];
        REG_DOWN_SEC:  down_sec = d[15:0];
        default: ;
      endcase
    endfunction

    function void clear_slot(int i);
      e_ip[i] = 0; e_mac[i] = 0; e_st[i] = ST_FREE; e_exp[i] = 0;
      e_tries[i] = 0; e_hv[i] = 0; e_hold[i] = 0;
    endfunction

    function void push(logic [2:0] act, logic [47:0] mac, logic [31:0] ip,
                       logic [15:0] h, logic res, logic lst);
      out_item_t o;
      o.action = act; o.dest_mac = mac; o.ip_addr_out = ip; o.handle = h;
      o.resolved = res; o.dup_ip_seen = dup; o.last = lst;
      pending_q.push_back(o);
    endfunction

    function int lookup(logic [31:0] ip);
      for (int i = 0; i < NENT; i++)
        if (e_st[i] != ST_FREE && e_ip[i] == ip) return i;
      return -1;
    endfunction

    // free slot first, then oldest solved, then oldest pending
    function int claim_slot(logic [31:0] ip, logic [31:0] now);
      int fr, so, pe, v;
      fr = -1; so = -1; pe = -1;
      for (int i = 0; i < NENT; i++) begin
        if (e_st[i] == ST_FREE) begin
          if (fr < 0) fr = i;
        end else if (e_st[i] == ST_SOLVED) begin
          if (so < 0 || e_exp[i] < e_exp[so]) so = i;
        end else begin
          if (pe < 0 || e_exp[i] < e_exp[pe]) pe = i;
        end
      end
      v = fr >= 0 ? fr : (so >= 0 ? so : pe);
      if (v < 0) return -1;
      if (e_hv[v]) push(ACT_RELEASE, 0, 0, e_hold[v], 0, 0);
      clear_slot(v);
      e_ip[v] = ip; e_st[v] = ST_PENDING; e_exp[v] = now;
      return v;
    endfunction

    function void note_input(in_item_t it);
      int e;
      logic [31:0] tip;
      logic [31:0] now;
      now = it.now_seconds;
      tip = it.target_ip;
      if (it.kind == KIND_RESOLVE) begin
        if (it.cast_kind == CAST_BCAST) begin
          push(ACT_ANSWER, MAC_BCAST, 0, 0, 1, 1); return;
        end
        if (it.cast_kind == CAST_MCAST) begin
          push(ACT_ANSWER, MAC_MCAST | {25'd0, it.ip_addr[22:0]}, 0, 0, 1, 1);
          return;
        end
        e = lookup(it.ip_addr);
        if (e < 0) e = claim_slot(it.ip_addr, now);
        if (e < 0) begin
          push(ACT_ANSWER, 0, 0, 0, 0, 1); return;
        end
        if (e_st[e] == ST_SOLVED && e_exp[e] > now) begin
          push(ACT_ANSWER, e_mac[e], 0, 0, 1, 1); return;
        end
        if (e_hv[e]) push(ACT_RELEASE, 0, 0, e_hold[e], 0, 0);
        e_hv[e] = 1; e_hold[e] = it.packet_handle;
        if (e_tries[e] == 0 || e_exp[e] != now) begin
          e_exp[e] = now;
          if (e_tries[e] < max_tries) begin
            e_tries[e]++;
            push(ACT_REQUEST, 0, it.ip_addr, 0, 0, 0);
          end else begin
            e_exp[e] = now + {16'd0, down_sec};
            e_tries[e] = 0;
          end
        end
        push(ACT_ANSWER, 0, 0, 0, 0, 1);
        return;
      end
      if (it.kind == KIND_ARP) begin
        if (it.sender_mac != MAC_BCAST) begin
          if (it.ip_addr == own_ip) begin
            tip = own_ip; dup = 1;
          end else begin
            e = lookup(it.ip_addr);
            if (e < 0 && tip == own_ip) e = claim_slot(it.ip_addr, now);
            if (e >= 0) begin
              e_mac[e] = it.sender_mac; e_st[e] = ST_SOLVED;
              e_exp[e] = now + {16'd0, keep_sec}; e_tries[e] = 0;
              if (e_hv[e]) begin
                push(ACT_TRANSMIT, it.sender_mac, 0, e_hold[e], 0, 0);
                e_hv[e] = 0; e_hold[e] = 0;
              end
            end
          end
          if (it.is_request && own_ip != 0 && tip == own_ip)
            push(ACT_REPLY, it.sender_mac, it.ip_addr, 0, 0, 0);
        end
      end else if (it.kind == KIND_SWEEP) begin
        for (int i = 0; i < NENT; i++)
          if (e_exp[i] != 0 && e_exp[i] <= now) begin
            if (e_hv[i]) push(ACT_RELEASE, 0, 0, e_hold[i], 0, 0);
            clear_slot(i);
          end
      end
      push(ACT_DONE, 0, 0, 0, 0, 1);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.action != exp_r.action || got.dest_mac != exp_r.dest_mac ||
          got.ip_addr_out != exp_r.ip_addr_out || got.handle != exp_r.handle ||
          got.resolved != exp_r.resolved || got.dup_ip_seen != exp_r.dup_ip_seen ||
          got.last != exp_r.last) begin
        $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_scoreboard sb;
  bit hold_off = 0;
  int idle_cycles = 0;
  logic [31:0] clock_s = 100;
  logic [31:0] ip_pool[8];

  arp_cache_engine_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    sb = new();
    sb.reset_state();
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap - 1) @(posedge clk);
        @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      out_stall <= 1;
    end
  end

  // Monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(in_item_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [47:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Wait for all expected results to arrive before touching registers
  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (2 * NENT + 20) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] k, logic [31:0] ip, logic [31:0] tip,
                                  logic [47:0] smac, logic rq, logic [1:0] cast,
                                  logic [15:0] h, logic [31:0] now);
    in_item_t it;
    it.kind = k; it.ip_addr = ip; it.target_ip = tip; it.sender_mac = smac;
    it.is_request = rq; it.cast_kind = cast; it.packet_handle = h;
    it.now_seconds = now;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    logic [31:0] ip, tip;
    logic [47:0] smac;
    int r;
    ip = ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
    tip = ($urandom_range(0, 1) == 0) ? sb.own_ip : $urandom();
    smac = {$urandom(), $urandom()};
    if ($urandom_range(0, 19) == 0) smac = MAC_BCAST;
    if ($urandom_range(0, 29) == 0) ip = sb.own_ip;
    clock_s = clock_s + $urandom_range(0, 3);
    if ($urandom_range(0, 49) == 0) clock_s = clock_s + $urandom_range(100, 3000);
    r = $urandom_range(0, 99);
    return mk(r < 50 ? KIND_RESOLVE : (r < 88 ? KIND_ARP : (r < 98 ? KIND_SWEEP : 2'd3)),
              ip, tip, smac, $urandom_range(0, 1),
              ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : 2'd0,
              16'($urandom()), clock_s);
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_item(rand_item(), 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default registers, unassigned address
    send_item(mk(KIND_RESOLVE, 32'hFFFF_FFFF, 0, 0, 0, CAST_BCAST, 16'hFFFF, 0), 0);
    send_item(mk(KIND_RESOLVE, 32'hFFFF_FFFF, 0, 0, 0, CAST_MCAST, 0, 0), 0);
    send_item(mk(KIND_RESOLVE, 32'h0, 0, 0, 0, 2'd0, 16'h0, 5), 0);
    send_item(mk(KIND_ARP, 32'h0A00_0001, 32'h0, MAC_BCAST, 1, 0, 0, 5), 0);
    send_item(mk(2'd3, $urandom(), 0, 0, 1, 2'd3, 16'hFFFF, 32'hFFFF_FFFF), 0);
    drain();

    write_cfg(REG_OWN_IP, 48'h0000_C0A8_0001);
    write_cfg(REG_OWN_MAC, 48'hFFFF_FFFF_FFFE);
    write_cfg(REG_KEEP_SEC, 48'd1);
    write_cfg(REG_MAX_TRIES, 48'd1);
    write_cfg(REG_DOWN_SEC, 48'd0);

    // Retry, back-off, learn, held transmit, duplicate, reply, sweep
    send_item(mk(KIND_RESOLVE, 32'h0A00_0002, 0, 0, 0, 2'd3, 16'hAAAA, 10), 0);
    send_item(mk(KIND_RESOLVE, 32'h0A00_0002, 0, 0, 0, 2'd0, 16'h5555, 10), 0);
    send_item(mk(KIND_RESOLVE, 32'h0A00_0002, 0, 0, 0, 2'd0, 16'h1234, 11), 0);
    send_item(mk(KIND_ARP, 32'h0A00_0002, 32'hC0A8_0001, 48'h0000_0000_0001, 1, 0, 0, 12), 0);
    send_item(mk(KIND_RESOLVE, 32'h0A00_0002, 0, 0, 0, 2'd0, 16'h1, 12), 0);
    send_item(mk(KIND_ARP, 32'hC0A8_0001, 32'h0, 48'h1234_5678_9ABC, 1, 0, 0, 12), 0);
    send_item(mk(KIND_ARP, 32'h0A00_0003, 32'h0A00_0009, 48'h2, 1, 0, 0, 12), 0);
    send_item(mk(KIND_RESOLVE, 32'h0A00_0004, 0, 0, 0, 2'd0, 16'h77, 13), 0);
    send_item(mk(KIND_SWEEP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
    // fill the table to force victim eviction
    for (int i = 0; i < NENT + 2; i++)
      send_item(mk(KIND_RESOLVE, 32'h0B00_0000 + i, 0, 0, 0, 2'd0, 16'(i), 20 + i), 1);
    drain();

    write_cfg(REG_OWN_IP, 48'h0000_FFFF_FFFF);
    write_cfg(REG_OWN_MAC, 48'h0);
    write_cfg(REG_KEEP_SEC, 48'hFFFF);
    write_cfg(REG_MAX_TRIES, 48'hFF);
    write_cfg(REG_DOWN_SEC, 48'hFFFF);
    for (int i = 0; i < 8; i++) ip_pool[i] = 32'h0A01_0000 + $urandom_range(0, 15);
    ip_pool[7] = 32'hFFFF_FFFF;
    random_phase(150);
    // long receiver hold-off with the sender pushing on
    hold_off = 1;
    for (int i = 0; i < 10; i++) send_item(rand_item(), 1);
    drain();

    write_cfg(REG_OWN_IP, {16'd0, 32'($urandom())});
    write_cfg(REG_OWN_MAC, {$urandom(), $urandom()});
    write_cfg(REG_KEEP_SEC, 48'd30);
    write_cfg(REG_MAX_TRIES, 48'd3);
    write_cfg(REG_DOWN_SEC, 48'd5);
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
    ip_pool[0] = 32'h0;
    random_phase(250);

    drain();
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
